>>> rtl/core/ehtx_pkg.sv
// Shared types, constants and elaboration-time tables for the equatorial/horizontal transform.
`timescale 1ns / 1ps
package ehtx_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int MAX_STEPS    = 62;
  localparam int NSTEPS       = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                                ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
  localparam int TURN_SHIFT   = 64 - ANGLE_BITS;

  localparam int ROT_LAT   = NSTEPS + 2;
  localparam int VEC_LAT   = NSTEPS + 2;
  localparam int MUL_LAT   = 4;
  localparam int TOTAL_LAT = 3 + ROT_LAT + 2 * VEC_LAT + 3 * MUL_LAT;

  // Transform direction
  localparam logic CMD_EQ_TO_HOR = 1'b0;
  localparam logic CMD_HOR_TO_EQ = 1'b1;

  localparam logic [63:0] ONE          = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_TURN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] EIGHTH_TURN  = 64'h2000_0000_0000_0000;
  localparam logic [63:0] INV_TWO_PI   = 64'h28BE_60DB_9391_054A;

  typedef struct packed {
    logic                         cmd;
    logic [ANGLE_BITS-1:0]        around_angle;
    logic signed [ANGLE_BITS-1:0] elevation_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] out_elevation;
    logic [ANGLE_BITS-1:0]        out_around;
  } out_item_t;

  // Shift-subtract division, used only while building the constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q60 product, round to nearest with ties away from zero.
  function automatic logic [63:0] mulq_c(input logic [63:0] a, input logic [63:0] b);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [63:0]  r;
    neg  = a[63] ^ b[63];
    ma   = a[63] ? (64'd0 - a) : a;
    mb   = b[63] ? (64'd0 - b) : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod + (128'd1 << 59);
    r    = prod[123:60];
    return neg ? (64'd0 - r) : r;
  endfunction

  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0]  rad;
    logic [63:0]  t;
    logic [127:0] prod;
    rad = '0;
    if (i == 0) begin
      return EIGHTH_TURN;
    end
    for (int k = 1; i * k < 64; k += 2) begin
      t = udiv64(64'd1 << (64 - i * k), 64'(k));
      if (((k >> 1) & 1) != 0) begin
        rad = rad - t;
      end else begin
        rad = rad + t;
      end
    end
    prod = {64'd0, rad} * {64'd0, INV_TWO_PI};
    return prod[127:64];
  endfunction

  function automatic logic [63:0] inv_gain_calc();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    p = ONE;
    for (int i = 0; i < NSTEPS; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    y = (ONE / 10) * 64'd6;
    for (int j = 0; j < 12; j++) begin
      t = mulq_c(p, mulq_c(y, y));
      y = mulq_c(y, 64'd3 * ONE - t) >> 1;
    end
    return y;
  endfunction

  localparam logic [63:0] INV_GAIN = inv_gain_calc();

endpackage

>>> rtl/core/ehtx_mul.sv
// Pipelined signed Q60 multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module ehtx_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        out_vld,
  output logic [63:0] p
);

  logic [3:0]   vld_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  ma_r, mb_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r;
  logic [63:0]  p_r;
  logic [127:0] sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign sum_nxt = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
                 + {p11_r, 64'd0} + (128'd1 << 59);

  always_ff @(posedge clk) begin
    neg1_r <= a[63] ^ b[63];
    ma_r   <= a[63] ? (64'd0 - a) : a;
    mb_r   <= b[63] ? (64'd0 - b) : b;
    neg2_r <= neg1_r;
    p00_r  <= ma_r[31:0]  * mb_r[31:0];
    p01_r  <= ma_r[31:0]  * mb_r[63:32];
    p10_r  <= ma_r[63:32] * mb_r[31:0];
    p11_r  <= ma_r[63:32] * mb_r[63:32];
    neg3_r <= neg2_r;
    prod_r <= sum_nxt;
    p_r    <= neg3_r ? (64'd0 - prod_r[123:60]) : prod_r[123:60];
  end

  assign out_vld = vld_r[3];
  assign p       = p_r;

endmodule

>>> rtl/core/ehtx_rot.sv
// Rotation-mode CORDIC pipeline: cosine and sine of a 64-bit binary angle.
`timescale 1ns / 1ps
module ehtx_rot (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] ang,
  output logic        out_vld,
  output logic [63:0] cos_o,
  output logic [63:0] sin_o
);

  localparam int N = ehtx_pkg::NSTEPS;

  logic [N+1:0] vld_r;
  logic [63:0]  x_r [N+1];
  logic [63:0]  y_r [N+1];
  logic [63:0]  z_r [N+1];
  logic [1:0]   q_r [N+1];
  logic [63:0]  c_r, s_r;
  logic [63:0]  rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N:0], in_vld};
    end
  end

  assign rnd_nxt = ang + ehtx_pkg::EIGHTH_TURN;

  // Fold into the quadrant around zero.
  always_ff @(posedge clk) begin
    q_r[0] <= rnd_nxt[63:62];
    z_r[0] <= ang - {rnd_nxt[63:62], 62'd0};
    x_r[0] <= ehtx_pkg::INV_GAIN;
    y_r[0] <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] ANG = ehtx_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      q_r[i+1] <= q_r[i];
      if (!z_r[i][63]) begin
        x_r[i+1] <= x_r[i] - 64'($signed(y_r[i]) >>> i);
        y_r[i+1] <= y_r[i] + 64'($signed(x_r[i]) >>> i);
        z_r[i+1] <= z_r[i] - ANG;
      end else begin
        x_r[i+1] <= x_r[i] + 64'($signed(y_r[i]) >>> i);
        y_r[i+1] <= y_r[i] - 64'($signed(x_r[i]) >>> i);
        z_r[i+1] <= z_r[i] + ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (q_r[N])
      2'd0: begin
        c_r <= x_r[N];
        s_r <= y_r[N];
      end
      2'd1: begin
        c_r <= 64'd0 - y_r[N];
        s_r <= x_r[N];
      end
      2'd2: begin
        c_r <= 64'd0 - x_r[N];
        s_r <= 64'd0 - y_r[N];
      end
      default: begin
        c_r <= y_r[N];
        s_r <= 64'd0 - x_r[N];
      end
    endcase
  end

  assign out_vld = vld_r[N+1];
  assign cos_o   = c_r;
  assign sin_o   = s_r;

endmodule

>>> rtl/core/ehtx_vec.sv
// Vectoring-mode CORDIC pipeline: angle and unscaled length of a 64-bit vector.
`timescale 1ns / 1ps
module ehtx_vec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  output logic        out_vld,
  output logic [63:0] ang_o,
  output logic [63:0] len_o
);

  localparam int N = ehtx_pkg::NSTEPS;

  logic [N+1:0] vld_r;
  logic [63:0]  x_r [N+1];
  logic [63:0]  y_r [N+1];
  logic [63:0]  z_r [N+1];
  logic         zero_r [N+1];
  logic         off_r [N+1];
  logic [63:0]  ang_r, len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N:0], in_vld};
    end
  end

  // Swing the left half-plane across by a half turn.
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_i == 64'd0) && (y_i == 64'd0);
    off_r[0]  <= x_i[63];
    x_r[0]    <= x_i[63] ? (64'd0 - x_i) : x_i;
    y_r[0]    <= x_i[63] ? (64'd0 - y_i) : y_i;
    z_r[0]    <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] ANG = ehtx_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      off_r[i+1]  <= off_r[i];
      if (!y_r[i][63]) begin
        x_r[i+1] <= x_r[i] + 64'($signed(y_r[i]) >>> i);
        y_r[i+1] <= y_r[i] - 64'($signed(x_r[i]) >>> i);
        z_r[i+1] <= z_r[i] + ANG;
      end else begin
        x_r[i+1] <= x_r[i] - 64'($signed(y_r[i]) >>> i);
        y_r[i+1] <= y_r[i] + 64'($signed(x_r[i]) >>> i);
        z_r[i+1] <= z_r[i] - ANG;
      end
    end
  end

  // A null vector gives angle and length zero.
  always_ff @(posedge clk) begin
    if (zero_r[N]) begin
      ang_r <= '0;
      len_r <= '0;
    end else begin
      ang_r <= z_r[N] + (off_r[N] ? ehtx_pkg::HALF_TURN : 64'd0);
      len_r <= x_r[N];
    end
  end

  assign out_vld = vld_r[N+1];
  assign ang_o   = ang_r;
  assign len_o   = len_r;

endmodule

>>> rtl/core/equatorial_horizontal_transform_core.sv
// Top level of the equatorial/horizontal coordinate transform pipeline.
`timescale 1ns / 1ps
// Usage
//   Input: drive in_data and raise start; a beat is taken at each rising edge
//   with start high and busy low. busy is low whenever rst_n is high, so one
//   beat can be taken every cycle.
//   cmd 0 maps hour angle and declination to altitude and azimuth from north;
//   cmd 1 maps azimuth and altitude back to declination and hour angle.
//   Result: out_valid is high for one cycle with out_data; it cannot be held
//   off, so the receiver must take every beat as it appears.
//   Pipeline: every beat passes through three CORDIC chains of stages + 2
//   registers each and three 4-stage 64-bit multipliers in series, with 30
//   CORDIC stages as configured. Throughput is one beat per cycle.
//   Configuration: cfg_data (observer latitude) is written when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high. Write it only while no
//   beat is in flight. The latitude is taken with each beat at entry.
//   Reset: synchronous, active low; clears all valid flags and sets the
//   latitude to zero. Beats in flight are dropped.
module equatorial_horizontal_transform_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  ehtx_pkg::in_item_t                       in_data,
  output logic                                     out_valid,
  output ehtx_pkg::out_item_t                      out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic signed [ehtx_pkg::ANGLE_BITS-1:0]   cfg_data
);

  localparam int AB  = ehtx_pkg::ANGLE_BITS;
  localparam int TS  = ehtx_pkg::TURN_SHIFT;
  localparam int RL  = ehtx_pkg::ROT_LAT;
  localparam int ML  = ehtx_pkg::MUL_LAT;
  localparam int VL  = ehtx_pkg::VEC_LAT;
  localparam int LAT = ehtx_pkg::TOTAL_LAT;

  logic [AB-1:0] lat_cfg_r;
  logic          v0_r;
  logic          cmd0_r;
  logic [63:0]   a0_r, e0_r, lat0_r;

  logic [63:0] a_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lat_cfg_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = !rst_n;

  assign a_nxt = {in_data.around_angle, {TS{1'b0}}}
               + ((in_data.cmd == ehtx_pkg::CMD_HOR_TO_EQ) ? ehtx_pkg::HALF_TURN : 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd0_r <= in_data.cmd;
    a0_r   <= a_nxt;
    e0_r   <= {in_data.elevation_angle, {TS{1'b0}}};
    lat0_r <= {lat_cfg_r, {TS{1'b0}}};
  end

  // sines and cosines
  logic        va, ve, vp;
  logic [63:0] ca, sa, ce, se, cp, sp;

  ehtx_rot u_rot_a (.clk, .rst_n, .in_vld(v0_r), .ang(a0_r),
                    .out_vld(va), .cos_o(ca), .sin_o(sa));
  ehtx_rot u_rot_e (.clk, .rst_n, .in_vld(v0_r), .ang(e0_r),
                    .out_vld(ve), .cos_o(ce), .sin_o(se));
  ehtx_rot u_rot_p (.clk, .rst_n, .in_vld(v0_r), .ang(lat0_r),
                    .out_vld(vp), .cos_o(cp), .sin_o(sp));

  logic cmd_rot_r [RL];
  always_ff @(posedge clk) begin
    cmd_rot_r[0] <= cmd0_r;
    for (int k = 1; k < RL; k++) begin
      cmd_rot_r[k] <= cmd_rot_r[k-1];
    end
  end

  // x and y on the unit sphere
  logic        vxx, vyy;
  logic [63:0] xx, yy;

  ehtx_mul u_mul_xx (.clk, .rst_n, .in_vld(va && ve && vp), .a(ce), .b(ca),
                     .out_vld(vxx), .p(xx));
  ehtx_mul u_mul_yy (.clk, .rst_n, .in_vld(va && ve && vp), .a(ce), .b(sa),
                     .out_vld(vyy), .p(yy));

  logic        cmd_m1_r [ML];
  logic [63:0] zz_m1_r [ML];
  logic [63:0] cp_m1_r [ML];
  logic [63:0] sp_m1_r [ML];
  always_ff @(posedge clk) begin
    cmd_m1_r[0] <= cmd_rot_r[RL-1];
    zz_m1_r[0]  <= se;
    cp_m1_r[0]  <= cp;
    sp_m1_r[0]  <= sp;
    for (int k = 1; k < ML; k++) begin
      cmd_m1_r[k] <= cmd_m1_r[k-1];
      zz_m1_r[k]  <= zz_m1_r[k-1];
      cp_m1_r[k]  <= cp_m1_r[k-1];
      sp_m1_r[k]  <= sp_m1_r[k-1];
    end
  end

  // latitude rotation products
  logic        vm1, vm2, vm3, vm4;
  logic [63:0] spz, cpx, spx, cpz;
  logic        v1_in;

  assign v1_in = vxx && vyy;

  ehtx_mul u_mul_spz (.clk, .rst_n, .in_vld(v1_in), .a(sp_m1_r[ML-1]), .b(zz_m1_r[ML-1]),
                      .out_vld(vm1), .p(spz));
  ehtx_mul u_mul_cpx (.clk, .rst_n, .in_vld(v1_in), .a(cp_m1_r[ML-1]), .b(xx),
                      .out_vld(vm2), .p(cpx));
  ehtx_mul u_mul_spx (.clk, .rst_n, .in_vld(v1_in), .a(sp_m1_r[ML-1]), .b(xx),
                      .out_vld(vm3), .p(spx));
  ehtx_mul u_mul_cpz (.clk, .rst_n, .in_vld(v1_in), .a(cp_m1_r[ML-1]), .b(zz_m1_r[ML-1]),
                      .out_vld(vm4), .p(cpz));

  logic        cmd_m2_r [ML];
  logic [63:0] yy_m2_r [ML];
  always_ff @(posedge clk) begin
    cmd_m2_r[0] <= cmd_m1_r[ML-1];
    yy_m2_r[0]  <= yy;
    for (int k = 1; k < ML; k++) begin
      cmd_m2_r[k] <= cmd_m2_r[k-1];
      yy_m2_r[k]  <= yy_m2_r[k-1];
    end
  end

  // combine; the inverse flips the sign of each cos(lat) term
  logic        vs_r;
  logic        cmd_s_r;
  logic [63:0] sel_r, u_r, yy_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= vm1 && vm2 && vm3 && vm4;
    end
  end

  always_ff @(posedge clk) begin
    cmd_s_r <= cmd_m2_r[ML-1];
    yy_s_r  <= yy_m2_r[ML-1];
    if (cmd_m2_r[ML-1] == ehtx_pkg::CMD_EQ_TO_HOR) begin
      sel_r <= spz + cpx;
      u_r   <= spx - cpz;
    end else begin
      sel_r <= spz - cpx;
      u_r   <= spx + cpz;
    end
  end

  // around angle and horizontal length
  logic        vv1;
  logic [63:0] ang1, len1;

  ehtx_vec u_vec_around (.clk, .rst_n, .in_vld(vs_r), .x_i(u_r), .y_i(yy_s_r),
                         .out_vld(vv1), .ang_o(ang1), .len_o(len1));

  logic        cmd_v1_r [VL];
  logic [63:0] sel_v1_r [VL];
  always_ff @(posedge clk) begin
    cmd_v1_r[0] <= cmd_s_r;
    sel_v1_r[0] <= sel_r;
    for (int k = 1; k < VL; k++) begin
      cmd_v1_r[k] <= cmd_v1_r[k-1];
      sel_v1_r[k] <= sel_v1_r[k-1];
    end
  end

  logic        vr;
  logic [63:0] rlen;

  ehtx_mul u_mul_gain (.clk, .rst_n, .in_vld(vv1), .a(len1), .b(ehtx_pkg::INV_GAIN),
                       .out_vld(vr), .p(rlen));

  logic [63:0] aro_m3_r [ML];
  logic [63:0] sel_m3_r [ML];
  always_ff @(posedge clk) begin
    aro_m3_r[0] <= ang1 + ((cmd_v1_r[VL-1] == ehtx_pkg::CMD_EQ_TO_HOR) ?
                           ehtx_pkg::HALF_TURN : 64'd0);
    sel_m3_r[0] <= sel_v1_r[VL-1];
    for (int k = 1; k < ML; k++) begin
      aro_m3_r[k] <= aro_m3_r[k-1];
      sel_m3_r[k] <= sel_m3_r[k-1];
    end
  end

  // elevation angle
  logic        vv2;
  logic [63:0] elev, len2;

  ehtx_vec u_vec_elev (.clk, .rst_n, .in_vld(vr), .x_i(rlen), .y_i(sel_m3_r[ML-1]),
                       .out_vld(vv2), .ang_o(elev), .len_o(len2));

  logic [63:0] aro_v2_r [VL];
  always_ff @(posedge clk) begin
    aro_v2_r[0] <= aro_m3_r[ML-1];
    for (int k = 1; k < VL; k++) begin
      aro_v2_r[k] <= aro_v2_r[k-1];
    end
  end

  // saturate to a quarter turn and round to the field width
  logic [63:0]         elev_sat;
  logic [63:0]         elev_rnd, aro_rnd;
  logic                out_valid_r;
  ehtx_pkg::out_item_t out_data_r;

  always_comb begin
    elev_sat = elev;
    if (!elev[63]) begin
      if (elev > ehtx_pkg::QUARTER_TURN) begin
        elev_sat = ehtx_pkg::QUARTER_TURN;
      end
    end else if (elev < (64'd0 - ehtx_pkg::QUARTER_TURN)) begin
      elev_sat = 64'd0 - ehtx_pkg::QUARTER_TURN;
    end
    elev_rnd = elev_sat + (64'd1 << (TS - 1));
    aro_rnd  = aro_v2_r[VL-1] + (64'd1 << (TS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vv2 && (len2 == len2);
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_elevation <= elev_rnd[63:TS];
    out_data_r.out_around    <= aro_rnd[63:TS];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not emerge after the pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.out_elevation) <= $signed(AB'(1) <<< (AB - 2)) &&
                   $signed(out_data.out_elevation) >= -$signed(AB'(1) <<< (AB - 2))))
    else $error("elevation result beyond a quarter turn");

endmodule
